FILE: design/wua_pkg.sv
`default_nettype none
package wua_pkg;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_CMP = 3'd3,
    OP_QUO = 3'd4,
    OP_REM = 3'd5
  } op_e;

  localparam logic [1:0] ORDER_GREATER = 2'd0;
  localparam logic [1:0] ORDER_LESS    = 2'd1;
  localparam logic [1:0] ORDER_EQUAL   = 2'd2;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
  } req_t;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  order;
    logic        divide_by_zero;
  } rsp_t;

endpackage
`default_nettype wire

FILE: design/wua_mul.sv
`default_nettype none
// low half of a*b over two stages: 32x32 partial products, then sum
module wua_mul #(
  parameter int unsigned W = 64
) (
  input  wire logic         clk_i,
  input  wire logic [W-1:0] a_i,
  input  wire logic [W-1:0] b_i,
  output logic [W-1:0]      p_o
);
  localparam int unsigned H = W / 2;
  localparam int unsigned L = W - H;

  logic [2*L-1:0] ll_q;
  logic [W-1:0]   lh_q, hl_q;
  logic [W-1:0]   lh_d, hl_d;

  assign lh_d = W'(a_i[L-1:0] * b_i[W-1:L]);
  assign hl_d = W'(a_i[W-1:L] * b_i[L-1:0]);

  always_ff @(posedge clk_i) begin
    ll_q <= a_i[L-1:0] * b_i[L-1:0];
    lh_q <= lh_d;
    hl_q <= hl_d;
  end

  assign p_o = W'(ll_q) + W'({lh_q + hl_q, L'(0)});
endmodule
`default_nettype wire

FILE: design/wua_div_stage.sv
`default_nettype none
// one restoring division step per instance, quotient bits shift in from the right
module wua_div_stage #(
  parameter int unsigned W = 64
) (
  input  wire logic [W-1:0] rem_i,
  input  wire logic [W-1:0] quo_i,
  input  wire logic [W-1:0] div_i,
  output logic [W-1:0]      rem_o,
  output logic [W-1:0]      quo_o
);
  logic [W:0] trial;
  logic [W:0] diff;
  always_comb begin
    trial = {rem_i, quo_i[W-1]};
    diff  = trial - {1'b0, div_i};
    if (!diff[W]) begin
      rem_o = diff[W-1:0];
      quo_o = {quo_i[W-2:0], 1'b1};
    end else begin
      rem_o = trial[W-1:0];
      quo_o = {quo_i[W-2:0], 1'b0};
    end
  end
endmodule
`default_nettype wire

FILE: design/wide_unsigned_alu.sv
`default_nettype none
// pipelined unsigned alu: add, subtract, low multiply, compare, quotient, remainder
// a word is taken at each rising edge with start high; busy is always low,
// so one word may enter every cycle
// every word walks the same pipeline: one input register, ceil(WIDTH/4) division
// stages of four restoring steps each (the divider sets the depth), then the
// output register; one result per cycle
// add, subtract, compare and multiply are worked out early and ride along
// res_valid_o is high for exactly one cycle per word with res_o holding it;
// the receiver cannot stall, results come out in order
// zero divisor gives value 0 and the divide_by_zero flag
// reset clears the valid bits only; words in flight are dropped
module wide_unsigned_alu #(
  parameter int unsigned WIDTH = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire wua_pkg::req_t    req_i,
  output logic                  res_valid_o,
  output wua_pkg::rsp_t         res_o
);
  import wua_pkg::*;

  localparam int unsigned STEPS = 4;
  localparam int unsigned NST   = (WIDTH + STEPS - 1) / STEPS;

  assign busy = 1'b0;

  // stage 0 registers
  logic             v0_q;
  logic [2:0]       op0_q;
  logic [WIDTH-1:0] a0_q, b0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else         v0_q <= start;
  end
  always_ff @(posedge clk_i) begin
    op0_q <= req_i.opcode;
    a0_q  <= req_i.operand_a[WIDTH-1:0];
    b0_q  <= req_i.operand_b[WIDTH-1:0];
  end

  logic [WIDTH-1:0] prod;
  wua_mul #(.W(WIDTH)) u_mul (.clk_i(clk_i), .a_i(a0_q), .b_i(b0_q), .p_o(prod));

  // divider pipeline, row k holds state after k groups
  logic             v_q   [NST+1];
  logic [2:0]       op_q  [NST+1];
  logic [WIDTH-1:0] rem_q [NST+1];
  logic [WIDTH-1:0] quo_q [NST+1];
  logic [WIDTH-1:0] div_q [NST+1];
  logic [WIDTH-1:0] fast_q[NST+1];
  logic [1:0]       ord_q [NST+1];

  logic [WIDTH-1:0] fast0;
  logic [1:0]       ord0;
  always_comb begin
    fast0 = '0;
    ord0  = ORDER_GREATER;
    case (op0_q)
      OP_ADD: fast0 = a0_q + b0_q;
      OP_SUB: fast0 = a0_q - b0_q;
      OP_CMP: begin
        if (a0_q > b0_q)      ord0 = ORDER_GREATER;
        else if (a0_q < b0_q) ord0 = ORDER_LESS;
        else                  ord0 = ORDER_EQUAL;
      end
      default: fast0 = '0;
    endcase
  end

  // row 0 combinational view of stage 0
  always_comb begin
    v_q[0]    = v0_q;
    op_q[0]   = op0_q;
    rem_q[0]  = '0;
    quo_q[0]  = a0_q;
    div_q[0]  = b0_q;
    fast_q[0] = fast0;
    ord_q[0]  = ord0;
  end

  logic [WIDTH-1:0] fast1;

  for (genvar k = 0; k < NST; k++) begin : g_div
    logic [WIDTH-1:0] r [STEPS+1];
    logic [WIDTH-1:0] q [STEPS+1];
    assign r[0] = rem_q[k];
    assign q[0] = quo_q[k];
    for (genvar s = 0; s < STEPS; s++) begin : g_step
      if (k*STEPS + s < WIDTH) begin : g_on
        wua_div_stage #(.W(WIDTH)) u_st (
          .rem_i(r[s]), .quo_i(q[s]), .div_i(div_q[k]),
          .rem_o(r[s+1]), .quo_o(q[s+1]));
      end else begin : g_off
        assign r[s+1] = r[s];
        assign q[s+1] = q[s];
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[k+1] <= 1'b0;
      else         v_q[k+1] <= v_q[k];
    end
    always_ff @(posedge clk_i) begin
      op_q[k+1]  <= op_q[k];
      rem_q[k+1] <= r[STEPS];
      quo_q[k+1] <= q[STEPS];
      div_q[k+1] <= div_q[k];
      ord_q[k+1] <= ord_q[k];
      // product registers alongside row 1, so it joins on the way out of it
      if (k == 1) fast_q[k+1] <= (op_q[k] == OP_MUL) ? prod : fast_q[k];
      else        fast_q[k+1] <= fast_q[k];
    end
  end

  assign fast1 = fast_q[NST];

  // output register
  rsp_t             rsp_d, rsp_q;
  logic             vo_q;
  logic             dz;
  logic [WIDTH-1:0] val;
  always_comb begin
    dz  = (div_q[NST] == '0);
    val = fast1;
    rsp_d = '0;
    case (op_q[NST])
      OP_QUO: val = dz ? '0 : quo_q[NST];
      OP_REM: val = dz ? '0 : rem_q[NST];
      default: val = fast1;
    endcase
    rsp_d.value = 64'(val);
    rsp_d.order = (op_q[NST] == OP_CMP) ? ord_q[NST] : ORDER_GREATER;
    rsp_d.divide_by_zero = dz && (op_q[NST] == OP_QUO || op_q[NST] == OP_REM);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vo_q <= 1'b0;
    else         vo_q <= v_q[NST];
  end
  always_ff @(posedge clk_i) rsp_q <= rsp_d;

  assign res_valid_o = vo_q;
  assign res_o       = rsp_q;
endmodule
`default_nettype wire

FILE: design/wua_checker.sv
`default_nettype none
module wua_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          res_valid_i,
  input wire wua_pkg::rsp_t res_i
);
  import wua_pkg::*;

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");
  a_order_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> res_i.order != 2'd3) else $error("bad order");
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_i.divide_by_zero |-> res_i.value == '0 && res_i.order == ORDER_GREATER)
    else $error("divide by zero result not clear");
  a_cmp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_i.order != ORDER_GREATER |-> res_i.value == '0 && !res_i.divide_by_zero)
    else $error("compare result carries value");
endmodule

bind wide_unsigned_alu wua_checker u_wua_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
  .res_valid_i(res_valid_o), .res_i(res_o));
`default_nettype wire

FILE: sim/wide_unsigned_alu_checker.sv
`default_nettype none
module wide_unsigned_alu_checker (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic          busy_i,
  input  wire wua_pkg::req_t req_i,
  input  wire logic          res_valid_i,
  input  wire wua_pkg::rsp_t res_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 results_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import wua_pkg::*;

  rsp_t alu_results_q[$];

  function automatic rsp_t alu_predict(req_t w);
    rsp_t r;
    logic [63:0] a;
    logic [63:0] b;
    a = w.operand_a;
    b = w.operand_b;
    r = '0;
    case (w.opcode)
      OP_ADD: r.value = a + b;
      OP_SUB: r.value = a - b;
      OP_MUL: r.value = a * b;
      OP_CMP: r.order = (a > b) ? ORDER_GREATER : (a < b) ? ORDER_LESS : ORDER_EQUAL;
      OP_QUO, OP_REM: begin
        if (b == '0) r.divide_by_zero = 1'b1;
        else r.value = (w.opcode == OP_QUO) ? a / b : a % b;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  initial begin
    fail_count_o = 0;
    results_seen_o = 0;
  end

  assign pending_o = alu_results_q.size();

  always @(posedge clk_i) begin
    rsp_t exp_r;
    if (rst_ni) begin
      if (res_valid_i) begin
        results_seen_o <= results_seen_o + 1;
        if (alu_results_q.size() == 0) begin
          $error("unexpected result word value=%h", res_i.value);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = alu_results_q.pop_front();
          if (res_i.value !== exp_r.value) begin
            $error("value: expected %h got %h", exp_r.value, res_i.value);
            fail_count_o <= fail_count_o + 1;
          end
          if (res_i.order !== exp_r.order) begin
            $error("order: expected %0d got %0d", exp_r.order, res_i.order);
            fail_count_o <= fail_count_o + 1;
          end
          if (res_i.divide_by_zero !== exp_r.divide_by_zero) begin
            $error("divide_by_zero: expected %0b got %0b", exp_r.divide_by_zero,
                   res_i.divide_by_zero);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (start_i && !busy_i) alu_results_q = {alu_results_q, alu_predict(req_i)};
    end
  end
endmodule
`default_nettype wire

FILE: sim/wide_unsigned_alu_tb.sv
`default_nettype none
module wide_unsigned_alu_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wua_pkg::*;

  localparam int unsigned WIDTH = 64;
  localparam int LATENCY = WIDTH / 4 + 2;
  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_WORDS = 600;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req = '0;
  logic res_valid;
  rsp_t res;
  int fail_count;
  int pending;
  int results_seen;
  int idle_cycles = 0;
  int words_sent = 0;
  int op_seen[8];

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  wide_unsigned_alu #(.WIDTH(WIDTH)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .req_i(req), .res_valid_o(res_valid), .res_o(res)
  );

  wide_unsigned_alu_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start), .busy_i(busy), .req_i(req),
    .res_valid_i(res_valid), .res_i(res), .fail_count_o(fail_count),
    .pending_o(pending), .results_seen_o(results_seen)
  );

  // watchdog on cycles with nothing accepted and no result out
  always @(posedge clk_i) begin
    if ((start && !busy) || res_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("wide_unsigned_alu test failed");
      $finish;
    end
  end

  function automatic logic [63:0] pick_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = '1;
      2: v = v >> $urandom_range(1, 63);
      3: v = 64'(1) << $urandom_range(0, 63);
      4: v = 64'($urandom_range(0, 15));
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_word(logic [2:0] op, logic [63:0] a, logic [63:0] b);
    int gap;
    start <= 1'b1;
    req <= '{opcode: op, operand_a: a, operand_b: b};
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    words_sent++;
    op_seen[op]++;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    logic [63:0] a;
    logic [63:0] b;
    logic [2:0] op;
    logic [63:0] q;
    int burst;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: extremes, every opcode, zero and exact divisors, unused codes
    send_word(OP_ADD, '1, 64'd1);
    send_word(OP_ADD, '1, '1);
    send_word(OP_SUB, '0, 64'd1);
    send_word(OP_SUB, 64'd5, 64'd5);
    send_word(OP_MUL, '1, '1);
    send_word(OP_MUL, 64'h1_0000_0000, 64'h1_0000_0000);
    send_word(OP_CMP, 64'd3, 64'd2);
    send_word(OP_CMP, 64'd2, 64'd3);
    send_word(OP_CMP, '1, '1);
    send_word(OP_QUO, 64'd100, '0);
    send_word(OP_REM, 64'd100, '0);
    send_word(OP_QUO, 64'd100, 64'd10);
    send_word(OP_REM, 64'd100, 64'd10);
    send_word(OP_QUO, '1, 64'd1);
    send_word(OP_REM, '1, '1);
    send_word(OP_QUO, 64'd7, '1);
    send_word(OP_REM, 64'd7, 64'h8000_0000_0000_0000);
    send_word(3'd6, '1, '1);
    send_word(3'd7, 64'd9, 64'd9);
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                        : 3'($urandom_range(0, 5));
      a = pick_operand();
      b = pick_operand();
      // exact divisions and equal compares now and then
      if ($urandom_range(0, 5) == 0) begin
        if (op == OP_CMP) b = a;
        else if (b != '0) begin
          q = pick_operand() >> $urandom_range(32, 63);
          a = q * b;
        end
      end
      // back-to-back bursts to fill the pipeline
      burst = ($urandom_range(0, 9) == 0) ? 1 : 0;
      if (burst != 0) begin
        start <= 1'b1;
        req <= '{opcode: op, operand_a: a, operand_b: b};
        @(posedge clk_i);
        while (busy) @(posedge clk_i);
        words_sent++;
        op_seen[op]++;
      end else begin
        send_word(op, a, b);
      end
    end
    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
    $display("%0d words sent, %0d results checked", words_sent, results_seen);
    $display("per opcode add/sub/mul/cmp/quo/rem/unused: %0d %0d %0d %0d %0d %0d %0d",
             op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4], op_seen[5],
             op_seen[6] + op_seen[7]);
    if (fail_count == 0) begin
      $display("wide_unsigned_alu test passed");
    end else begin
      $display("wide_unsigned_alu test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
